FILE: sv/csa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the circular stack ALU.
// No dependencies; imported by every module of the block.
package csa_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int DATA_WIDTH  = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);

    typedef enum logic [3:0] {
        OP_PUSH   = 4'd0,
        OP_POP    = 4'd1,
        OP_DROP   = 4'd2,
        OP_BACK   = 4'd3,
        OP_DUP    = 4'd4,
        OP_SWAP   = 4'd5,
        OP_OVER   = 4'd6,
        OP_ADD    = 4'd7,
        OP_AND    = 4'd8,
        OP_OR     = 4'd9,
        OP_XOR    = 4'd10,
        OP_INVERT = 4'd11,
        OP_NEGATE = 4'd12
    } csa_op_t;

    typedef enum logic [1:0] {
        SHIFT_HOLD,
        SHIFT_PUSH,
        SHIFT_POP
    } csa_shift_t;

    typedef struct packed {
        logic        [3:0]  req_type;
        logic signed [31:0] push_value;
    } csa_req_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic signed [31:0] second_value;
        logic signed [31:0] popped_value;
        logic        [2:0]  stack_pointer;
    } csa_rsp_t;

    // Update command from the ALU to the register file.
    typedef struct packed {
        csa_shift_t            shift;
        logic [DATA_WIDTH-1:0] top_data;
        logic [DATA_WIDTH-1:0] second_data;
    } csa_ctrl_t;

    // Fixed taps of the rotating register file, relative to the top.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] r0;
        logic [DATA_WIDTH-1:0] r1;
        logic [DATA_WIDTH-1:0] r2;
        logic [DATA_WIDTH-1:0] rl;
        logic [PTR_W-1:0]      ptr;
    } csa_view_t;

endpackage

FILE: sv/csa_alu.sv
`timescale 1ns / 1ps
// Operation decode and datapath: computes the new top, second entry, shift and popped value.
// Depends on csa_pkg.
module csa_alu
    import csa_pkg::*;
(
    input  csa_req_t              req,
    input  csa_view_t             view,
    output csa_ctrl_t             ctrl,
    output logic [DATA_WIDTH-1:0] popped
);

    logic [DATA_WIDTH-1:0] val;

    assign val = DATA_WIDTH'($unsigned(req.push_value));

    always_comb begin
        ctrl.shift       = SHIFT_HOLD;
        ctrl.top_data    = view.r0;
        ctrl.second_data = view.r1;
        popped           = '0;
        unique case (csa_op_t'(req.req_type))
            OP_PUSH: begin
                ctrl.shift       = SHIFT_PUSH;
                ctrl.top_data    = val;
                ctrl.second_data = view.r0;
            end
            OP_POP, OP_DROP: begin
                ctrl.shift       = SHIFT_POP;
                ctrl.top_data    = view.r1;
                ctrl.second_data = view.r2;
                popped           = view.r0;
            end
            OP_BACK: begin
                ctrl.shift       = SHIFT_PUSH;
                ctrl.top_data    = view.rl;
                ctrl.second_data = view.r0;
            end
            OP_DUP: begin
                ctrl.shift       = SHIFT_PUSH;
                ctrl.top_data    = view.r0;
                ctrl.second_data = view.r0;
            end
            OP_SWAP: begin
                ctrl.top_data    = view.r1;
                ctrl.second_data = view.r0;
            end
            OP_OVER: begin
                ctrl.shift       = SHIFT_PUSH;
                ctrl.top_data    = view.r1;
                ctrl.second_data = view.r0;
            end
            OP_ADD: begin
                ctrl.shift       = SHIFT_POP;
                ctrl.top_data    = view.r1 + view.r0;
                ctrl.second_data = view.r2;
            end
            OP_AND: begin
                ctrl.shift       = SHIFT_POP;
                ctrl.top_data    = view.r1 & view.r0;
                ctrl.second_data = view.r2;
            end
            OP_OR: begin
                ctrl.shift       = SHIFT_POP;
                ctrl.top_data    = view.r1 | view.r0;
                ctrl.second_data = view.r2;
            end
            OP_XOR: begin
                ctrl.shift       = SHIFT_POP;
                ctrl.top_data    = view.r1 ^ view.r0;
                ctrl.second_data = view.r2;
            end
            OP_INVERT: ctrl.top_data = ~view.r0;
            OP_NEGATE: ctrl.top_data = '0 - view.r0;
            default: begin
                ctrl.shift = SHIFT_HOLD;
            end
        endcase
    end

endmodule

FILE: sv/csa_stack.sv
`timescale 1ns / 1ps
// Rotating register file with the stack pointer; entry 0 is always the top.
// Depends on csa_pkg.
module csa_stack
    import csa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  csa_ctrl_t        ctrl,
    output csa_view_t        view,
    output logic [PTR_W-1:0] ptr_next
);

    logic [DATA_WIDTH-1:0] cell_reg  [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] cell_next [STACK_DEPTH];
    logic [PTR_W-1:0]      ptr_reg;

    // Rotate the whole file so the top stays at entry 0.
    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        localparam int Deeper  = (k + STACK_DEPTH - 1) % STACK_DEPTH;
        localparam int Shallow = (k + 1) % STACK_DEPTH;

        always_comb begin
            if (k == 0) begin
                cell_next[k] = ctrl.top_data;
            end else if (k == 1) begin
                cell_next[k] = ctrl.second_data;
            end else begin
                unique case (ctrl.shift)
                    SHIFT_PUSH: cell_next[k] = cell_reg[Deeper];
                    SHIFT_POP:  cell_next[k] = cell_reg[Shallow];
                    default:    cell_next[k] = cell_reg[k];
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cell_reg[k] <= '0;
            end else if (en) begin
                cell_reg[k] <= cell_next[k];
            end
        end
    end

    always_comb begin
        unique case (ctrl.shift)
            SHIFT_PUSH: ptr_next = (ptr_reg == PTR_W'(STACK_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            SHIFT_POP:  ptr_next = (ptr_reg == '0) ? PTR_W'(STACK_DEPTH - 1) : ptr_reg - 1'b1;
            default:    ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (en) begin
            ptr_reg <= ptr_next;
        end
    end

    assign view.r0  = cell_reg[0];
    assign view.r1  = cell_reg[1];
    assign view.r2  = cell_reg[2];
    assign view.rl  = cell_reg[STACK_DEPTH-1];
    assign view.ptr = ptr_reg;

endmodule

FILE: sv/circular_stack_alu.sv
`timescale 1ns / 1ps
// Circular Forth-style data stack with ALU: input register, datapath, result register.
// Depends on csa_pkg, csa_alu and csa_stack.

// One result transaction per input transaction, one transaction per clock cycle
// sustained while neither channel stalls. A request sits in the input register, the
// eight-entry rotating register file and the pointer update as it leaves it, and
// the result register presents the new top, second entry, popped value and
// pointer. Both channels stall independently; the input register refills in the
// same cycle the result register is emptied. The stack and pointer are cleared to
// zero by reset.
module circular_stack_alu
    import csa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  csa_req_t s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output csa_rsp_t m_payload
);

    logic                  in_valid_reg;
    csa_req_t              req_reg;
    logic                  m_valid_reg;
    csa_rsp_t              rsp_reg;
    csa_rsp_t              rsp_next;
    logic                  process;
    csa_view_t             view;
    csa_ctrl_t             ctrl;
    logic [DATA_WIDTH-1:0] popped;
    logic [PTR_W-1:0]      ptr_next;

    assign process = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_payload;
        end
    end

    csa_alu u_alu (
        .req    (req_reg),
        .view   (view),
        .ctrl   (ctrl),
        .popped (popped)
    );

    csa_stack u_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (process),
        .ctrl     (ctrl),
        .view     (view),
        .ptr_next (ptr_next)
    );

    always_comb begin
        rsp_next.top_value     = 32'(ctrl.top_data);
        rsp_next.second_value  = 32'(ctrl.second_data);
        rsp_next.popped_value  = 32'(popped);
        rsp_next.stack_pointer = 3'(ptr_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (process) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = rsp_reg;

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> m_valid_reg)
        else $error("processed transaction produced no result");

    a_request_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !process |=> in_valid_reg && $stable(req_reg))
        else $error("pending request lost before processing");

    a_push_top: assert property (@(posedge aclk) disable iff (!aresetn)
        process && req_reg.req_type == OP_PUSH
        |=> m_payload.top_value == $past(req_reg.push_value)
            && m_payload.stack_pointer == 3'($past(view.ptr) + 1'b1))
        else $error("push did not place value on top");

    a_pop_pointer: assert property (@(posedge aclk) disable iff (!aresetn)
        process && (req_reg.req_type == OP_POP || req_reg.req_type == OP_DROP)
        |=> m_payload.popped_value == 32'($past(view.r0))
            && m_payload.stack_pointer == 3'($past(view.ptr) - 1'b1))
        else $error("pop returned wrong value or pointer");

endmodule

FILE: sim/circular_stack_alu_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for circular_stack_alu: directed and random stack words with
// random stalls on both channels. Depends on csa_pkg and the circular_stack_alu RTL.
module circular_stack_alu_tb;
    import csa_pkg::*;

    localparam logic [3:0] OP_CODE_TOP = 4'hF;
    localparam int SLOT_COUNT = 8;

    class stack_tracker;
        logic [31:0] slots [SLOT_COUNT];
        logic [2:0]  top_ptr;
        csa_rsp_t    expected_rsp [$];
        int          failures;
        int          received;

        function new();
            foreach (slots[i]) slots[i] = '0;
            top_ptr  = '0;
            failures = 0;
            received = 0;
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        function void note_request(csa_req_t req);
            logic [2:0]  p;
            logic [2:0]  q;
            logic [2:0]  below;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] removed;
            csa_rsp_t    rsp;
            p       = top_ptr;
            q       = p - 3'd1;
            a       = slots[p];
            b       = slots[q];
            removed = '0;
            case (req.req_type)
                OP_PUSH: begin
                    p = p + 3'd1;
                    slots[p] = req.push_value;
                end
                OP_POP, OP_DROP: begin
                    removed = a;
                    p = q;
                end
                OP_BACK: p = p + 3'd1;
                OP_DUP: begin
                    p = p + 3'd1;
                    slots[p] = a;
                end
                OP_SWAP: begin
                    slots[q] = a;
                    slots[p] = b;
                end
                OP_OVER: begin
                    p = p + 3'd1;
                    slots[p] = b;
                end
                OP_ADD: begin
                    p = q;
                    slots[p] = b + a;
                end
                OP_AND: begin
                    p = q;
                    slots[p] = b & a;
                end
                OP_OR: begin
                    p = q;
                    slots[p] = b | a;
                end
                OP_XOR: begin
                    p = q;
                    slots[p] = b ^ a;
                end
                OP_INVERT: slots[p] = ~a;
                OP_NEGATE: slots[p] = 32'd0 - a;
                default: ;
            endcase
            top_ptr = p;
            below   = p - 3'd1;
            rsp.top_value     = slots[p];
            rsp.second_value  = slots[below];
            rsp.popped_value  = removed;
            rsp.stack_pointer = p;
            expected_rsp.push_back(rsp);
        endfunction

        function void check_response(csa_rsp_t got);
            csa_rsp_t exp_rsp;
            received++;
            if (expected_rsp.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result transaction: top %h second %h popped %h ptr %0d",
                             got.top_value, got.second_value, got.popped_value,
                             got.stack_pointer);
                return;
            end
            exp_rsp = expected_rsp.pop_front();
            if (got.top_value !== exp_rsp.top_value ||
                got.second_value !== exp_rsp.second_value ||
                got.popped_value !== exp_rsp.popped_value ||
                got.stack_pointer !== exp_rsp.stack_pointer) begin
                failures++;
                if (failures <= 10)
                    $display({"mismatch at result %0d: exp top %h second %h popped %h ",
                              "ptr %0d, got top %h second %h popped %h ptr %0d"},
                             received, exp_rsp.top_value, exp_rsp.second_value,
                             exp_rsp.popped_value, exp_rsp.stack_pointer,
                             got.top_value, got.second_value, got.popped_value,
                             got.stack_pointer);
            end
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    csa_req_t s_payload;
    logic     m_valid;
    logic     m_ready;
    csa_rsp_t m_payload;

    stack_tracker tracker;

    circular_stack_alu dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(30, 8);
    endfunction

    task automatic send_request(csa_req_t req, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(req);
    endtask

    task automatic send_word(logic [3:0] code, logic [31:0] value);
        csa_req_t req;
        req.req_type   = code;
        req.push_value = value;
        send_request(req, idle_gap());
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_response(m_payload);
    end

    // Receiver side: random stalls, plus one long hold-off to back the block up.
    initial begin
        bit long_hold_done;
        int g;
        long_hold_done = 1'b0;
        m_ready        = 1'b0;
        wait (aresetn);
        forever begin
            if (!long_hold_done && tracker.received >= 60) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold_done = 1'b1;
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(posedge aclk);
            g = idle_gap();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        csa_req_t    req;
        logic [31:0] extremes [5];
        int          r;
        int          guard;
        tracker   = new();
        extremes  = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000};
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(OP_PUSH, 32'h7FFF_FFFF);
        send_word(OP_PUSH, 32'h0000_0001);
        send_word(OP_ADD, 32'hFFFF_FFFF);
        send_word(OP_NEGATE, 32'h0);
        send_word(OP_PUSH, 32'hFFFF_FFFF);
        send_word(OP_PUSH, 32'h8000_0000);
        send_word(OP_XOR, 32'h0);
        send_word(OP_INVERT, 32'h0);
        send_word(OP_PUSH, 32'h5555_5555);
        send_word(OP_AND, 32'h0);
        send_word(OP_PUSH, 32'h0F0F_0F0F);
        send_word(OP_OR, 32'hAAAA_AAAA);
        send_word(OP_DUP, 32'h0);
        send_word(OP_OVER, 32'h0);
        send_word(OP_SWAP, 32'h0);
        send_word(OP_POP, 32'h0);
        send_word(OP_DROP, 32'h0);
        send_word(OP_BACK, 32'h0);
        for (int c = OP_NEGATE + 1; c <= OP_CODE_TOP; c++)
            send_word(c[3:0], 32'hFFFF_FFFF);
        for (int k = 0; k < 4; k++)
            send_word(OP_POP, 32'h0);

        for (int n = 0; n < 450; n++) begin
            r = $urandom_range(99, 0);
            if (r < 35)
                req.req_type = OP_PUSH;
            else if (r < 45)
                req.req_type = ($urandom_range(1, 0) != 0) ? OP_POP : OP_DROP;
            else if (r < 50)
                req.req_type = OP_BACK;
            else if (r < 65)
                req.req_type = 4'($urandom_range(OP_OVER, OP_DUP));
            else if (r < 90)
                req.req_type = 4'($urandom_range(OP_XOR, OP_ADD));
            else if (r < 97)
                req.req_type = ($urandom_range(1, 0) != 0) ? OP_INVERT : OP_NEGATE;
            else
                req.req_type = 4'($urandom_range(OP_CODE_TOP, OP_NEGATE + 1));
            if ($urandom_range(99, 0) < 20)
                req.push_value = extremes[$urandom_range(4, 0)];
            else
                req.push_value = $urandom;
            send_request(req, idle_gap());
        end
        s_valid <= 1'b0;

        guard = 0;
        while (tracker.pending() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10) @(posedge aclk);
        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
